>>> rtl/jet_pkg.sv
// Shared types, constants and helper functions of the Julia escape-time iterator.
package jet_pkg;

  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 16;

  localparam int Q_W       = 32;
  localparam int C_W       = 31;
  localparam int MAXIT_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int FRAC_BITS = 28;
  localparam int PROD_W    = 2 * Q_W;
  localparam int MAP_W     = COORD_BITS + 22;

  localparam int STEP_X = 419649;
  localparam int STEP_Y = 746345;
  localparam int OFF_X  = 348966093;
  localparam int OFF_Y  = 322122547;

  localparam logic [PROD_W-1:0] ESCAPE_LIM = PROD_W'(64'd1 << 58);
  localparam logic [MAXIT_W-1:0] MAX_ITER_RST = MAXIT_W'(256);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL   = 2'd0,
    CFG_C_IMAG   = 2'd1,
    CFG_MAX_ITER = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD
  } back_state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [ITER_BITS-1:0]  iterations;
    logic                  inside_res;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
  } res_t;

  typedef struct packed {
    logic signed [Q_W-1:0] zr;
    logic signed [Q_W-1:0] zi;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } start_pt_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > PROD_W'(64'sh7FFF_FFFF)) begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < -PROD_W'(64'sh8000_0000)) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = Q_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/jet_front.sv
// Front end: accepts pixel requests and maps them to complex start points.
module jet_front (
  input  logic                 start_i,
  input  logic                 full_i,
  input  jet_pkg::req_t        req_i,
  output logic                 push_o,
  output jet_pkg::start_pt_t   entry_o
);

  logic signed [jet_pkg::MAP_W-1:0] px_s;
  logic signed [jet_pkg::MAP_W-1:0] py_s;
  logic signed [jet_pkg::MAP_W-1:0] map_x;
  logic signed [jet_pkg::MAP_W-1:0] map_y;

  always_comb begin
    px_s  = jet_pkg::MAP_W'(req_i.pixel_x);
    py_s  = jet_pkg::MAP_W'(req_i.pixel_y);
    map_x = px_s * jet_pkg::MAP_W'(jet_pkg::STEP_X) - jet_pkg::MAP_W'(jet_pkg::OFF_X);
    map_y = py_s * jet_pkg::MAP_W'(jet_pkg::STEP_Y) - jet_pkg::MAP_W'(jet_pkg::OFF_Y);
  end

  assign push_o      = start_i && !full_i;
  assign entry_o.zr  = jet_pkg::sat_q(jet_pkg::PROD_W'(map_x));
  assign entry_o.zi  = jet_pkg::sat_q(jet_pkg::PROD_W'(map_y));
  assign entry_o.px  = req_i.pixel_x;
  assign entry_o.py  = req_i.pixel_y;

endmodule

>>> rtl/jet_queue.sv
// Short queue of start points between the front end and the iteration engine.
module jet_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jet_pkg::start_pt_t push_data_i,
  input  logic               pop_i,
  output jet_pkg::start_pt_t head_o,
  output logic               full_o,
  output logic               empty_o
);

  jet_pkg::start_pt_t mem_q [jet_pkg::QDEPTH];
  logic [jet_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [jet_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [jet_pkg::QCNT_W-1:0] count_q, count_d;

  function automatic logic [jet_pkg::QPTR_W-1:0] ptr_inc(input logic [jet_pkg::QPTR_W-1:0] p);
    logic [jet_pkg::QPTR_W-1:0] r;
    if (p == jet_pkg::QPTR_W'(jet_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = count_q == jet_pkg::QCNT_W'(jet_pkg::QDEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Queue written while full.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("Queue read while empty.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= jet_pkg::QCNT_W'(jet_pkg::QDEPTH))
    else $error("Queue fill count out of range.");

endmodule

>>> rtl/jet_back.sv
// Iteration engine: runs z = z*z + c on one start point and emits the result.
module jet_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  jet_pkg::start_pt_t            head_i,
  input  logic signed [jet_pkg::C_W-1:0] c_real_i,
  input  logic signed [jet_pkg::C_W-1:0] c_imag_i,
  input  logic [jet_pkg::ITER_BITS-1:0] limit_i,
  output logic                          pop_o,
  output logic                          done_o,
  output jet_pkg::res_t                 res_o
);

  jet_pkg::back_state_e state_q, state_d;

  logic signed [jet_pkg::Q_W-1:0]    zr_q, zr_d, zi_q, zi_d;
  logic [jet_pkg::COORD_BITS-1:0]    px_q, px_d, py_q, py_d;
  logic [jet_pkg::ITER_BITS-1:0]     it_q, it_d;
  logic signed [jet_pkg::PROD_W-1:0] prr_q, prr_d, pii_q, pii_d, pri_q, pri_d;
  logic                              done_q, done_d;
  jet_pkg::res_t                     res_q, res_d;

  logic [jet_pkg::PROD_W-1:0]        mag;
  logic                              escaped;
  logic                              at_limit;
  logic                              finish;
  logic signed [jet_pkg::Q_W-1:0]    nr;
  logic signed [jet_pkg::Q_W-1:0]    ni;

  always_comb begin
    mag      = $unsigned(prr_q) + $unsigned(pii_q);
    escaped  = (it_q != '0) && (mag >= jet_pkg::ESCAPE_LIM);
    at_limit = it_q == limit_i;
    finish   = escaped || at_limit;
    nr = jet_pkg::sat_q(((prr_q - pii_q) >>> jet_pkg::FRAC_BITS)
                        + jet_pkg::PROD_W'(c_real_i));
    ni = jet_pkg::sat_q((pri_q >>> (jet_pkg::FRAC_BITS - 1))
                        + jet_pkg::PROD_W'(c_imag_i));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      jet_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = jet_pkg::BK_MUL;
        end
      end
      jet_pkg::BK_MUL: begin
        state_d = jet_pkg::BK_UPD;
      end
      jet_pkg::BK_UPD: begin
        state_d = finish ? jet_pkg::BK_IDLE : jet_pkg::BK_MUL;
      end
      default: begin
        state_d = jet_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    zr_d   = zr_q;
    zi_d   = zi_q;
    px_d   = px_q;
    py_d   = py_q;
    it_d   = it_q;
    prr_d  = prr_q;
    pii_d  = pii_q;
    pri_d  = pri_q;
    done_d = 1'b0;
    res_d  = res_q;
    case (state_q)
      jet_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          zr_d  = head_i.zr;
          zi_d  = head_i.zi;
          px_d  = head_i.px;
          py_d  = head_i.py;
          it_d  = '0;
        end
      end
      jet_pkg::BK_MUL: begin
        prr_d = zr_q * zr_q;
        pii_d = zi_q * zi_q;
        pri_d = zr_q * zi_q;
      end
      jet_pkg::BK_UPD: begin
        if (finish) begin
          done_d           = 1'b1;
          res_d.iterations = it_q;
          res_d.inside_res = at_limit;
          res_d.out_x      = px_q;
          res_d.out_y      = py_q;
        end else begin
          zr_d = nr;
          zi_d = ni;
          it_d = it_q + 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jet_pkg::BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q  <= zr_d;
    zi_q  <= zi_d;
    px_q  <= px_d;
    py_q  <= py_d;
    it_q  <= it_d;
    prr_q <= prr_d;
    pii_q <= pii_d;
    pri_q <= pri_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(state_q == jet_pkg::BK_UPD))
    else $error("Result strobe without a finishing update step.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != jet_pkg::BK_IDLE) |-> (it_q <= limit_i))
    else $error("Iteration count passed the limit.");

  a_inside_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.inside_res == (res_q.iterations == limit_i)))
    else $error("Inside flag disagrees with the iteration count.");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !done_d)
    else $error("Result strobe lasted more than one cycle.");

endmodule

>>> rtl/julia_escape_time_iterator.sv
// Top level of the Julia escape-time iterator: configuration, queue, front and back ends.
//
//   Channel   Signals                               Transfer
//   request   start_i, busy_o, req_i                start_i && !busy_o
//   result    done_o, res_o                         done_o, one cycle, no stall
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,  cfg_valid_i && cfg_ready_o
//             cfg_data_i
//
// A request occupies the iteration engine from its pop in BK_IDLE to the finishing BK_UPD
// step; the result strobe is registered from that step and rises in the cycle after it.
// Each iteration forms the three products in BK_MUL and then updates z in BK_UPD.
// Up to two requests wait in the queue; busy_o is high while it is full.
// Reset clears the queue and sets c to zero and the iteration limit to 256.
module julia_escape_time_iterator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  jet_pkg::req_t                   req_i,
  output logic                            done_o,
  output jet_pkg::res_t                   res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jet_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jet_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  logic signed [jet_pkg::C_W-1:0] c_real_q;
  logic signed [jet_pkg::C_W-1:0] c_imag_q;
  logic [jet_pkg::MAXIT_W-1:0]    max_iter_q;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  jet_pkg::start_pt_t entry;
  jet_pkg::start_pt_t head;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q   <= '0;
      c_imag_q   <= '0;
      max_iter_q <= jet_pkg::MAX_ITER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        jet_pkg::CFG_C_REAL:   c_real_q   <= cfg_data_i[jet_pkg::C_W-1:0];
        jet_pkg::CFG_C_IMAG:   c_imag_q   <= cfg_data_i[jet_pkg::C_W-1:0];
        jet_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[jet_pkg::MAXIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jet_front u_front (
    .start_i (start_i),
    .full_i  (full),
    .req_i   (req_i),
    .push_o  (push),
    .entry_o (entry)
  );

  jet_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  jet_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .c_real_i (c_real_q),
    .c_imag_i (c_imag_q),
    .limit_i  (jet_pkg::ITER_BITS'(max_iter_q)),
    .pop_o    (pop),
    .done_o   (done_o),
    .res_o    (res_o)
  );

endmodule

>>> sim/julia_escape_time_iterator_tb.sv
// Self-checking testbench of the Julia escape-time iterator with its own fixed-point predictor.
module julia_escape_time_iterator_tb;

  localparam int WATCHDOG_LIMIT = 1_000_000;
  localparam logic [63:0] ESCAPE_Q856 = 64'd1 << 58;
  localparam longint Q4_28_MAX = 64'sd2147483647;
  localparam longint Q4_28_MIN = -64'sd2147483648;
  localparam logic [31:0] C_PLUS_TWO = 32'h2000_0000;
  localparam logic [31:0] C_MINUS_TWO = 32'h6000_0000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  jet_pkg::req_t                 req_i;
  logic                          done_o;
  jet_pkg::res_t                 res_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [jet_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [jet_pkg::CFG_DAT_W-1:0] cfg_data_i;

  longint      c_re;
  longint      c_im;
  int unsigned iter_limit;
  bit          idle_on;

  jet_pkg::res_t expected_res_q[$];
  jet_pkg::res_t next_res;
  int          mismatch_count;
  int          items_sent;
  int          results_checked;
  int          inside_seen;
  int          deepest_count;
  int          idle_cycles;

  julia_escape_time_iterator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_q(input longint v);
    if (v > Q4_28_MAX) begin
      return Q4_28_MAX;
    end else if (v < Q4_28_MIN) begin
      return Q4_28_MIN;
    end
    return v;
  endfunction

  function automatic jet_pkg::res_t predict_pixel(input jet_pkg::req_t px);
    jet_pkg::res_t r;
    longint      zr;
    longint      zi;
    longint      rr;
    longint      ii;
    longint      ri;
    logic [63:0] mag2;
    int unsigned n;
    bit          escaped;
    zr = clamp_q(longint'(px.pixel_x) * jet_pkg::STEP_X - jet_pkg::OFF_X);
    zi = clamp_q(longint'(px.pixel_y) * jet_pkg::STEP_Y - jet_pkg::OFF_Y);
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < iter_limit) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      zr = clamp_q(((rr - ii) >>> jet_pkg::FRAC_BITS) + c_re);
      zi = clamp_q((ri >>> (jet_pkg::FRAC_BITS - 1)) + c_im);
      n++;
      mag2 = zr * zr + zi * zi;
      escaped = (mag2 >= ESCAPE_Q856);
    end
    r.iterations = n[jet_pkg::ITER_BITS-1:0];
    r.inside_res = (n == iter_limit);
    r.out_x = px.pixel_x;
    r.out_y = px.pixel_y;
    return r;
  endfunction

  function automatic jet_pkg::req_t random_pixel();
    jet_pkg::req_t px;
    if ($urandom_range(0, 9) < 7) begin
      px.pixel_x = jet_pkg::COORD_BITS'($urandom_range(0, 1919));
      px.pixel_y = jet_pkg::COORD_BITS'($urandom_range(0, 1079));
    end else begin
      px.pixel_x = jet_pkg::COORD_BITS'($urandom);
      px.pixel_y = jet_pkg::COORD_BITS'($urandom);
    end
    return px;
  endfunction

  function automatic logic [31:0] random_constant();
    int v;
    v = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    return {1'($urandom), 31'(v)};
  endfunction

  task automatic send_pixel(input logic [jet_pkg::COORD_BITS-1:0] x,
                            input logic [jet_pkg::COORD_BITS-1:0] y);
    jet_pkg::req_t px;
    px.pixel_x = x;
    px.pixel_y = y;
    start_i <= 1'b1;
    req_i <= px;
    do @(posedge clk_i); while (busy_o);
    expected_res_q.push_back(predict_pixel(px));
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_julia_params(input logic [31:0] re_data, input logic [31:0] im_data,
                                   input logic [31:0] limit_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= jet_pkg::CFG_C_REAL;
    cfg_data_i <= re_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    c_re = longint'($signed(re_data[30:0]));
    cfg_index_i <= jet_pkg::CFG_C_IMAG;
    cfg_data_i <= im_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    c_im = longint'($signed(im_data[30:0]));
    cfg_index_i <= jet_pkg::CFG_MAX_ITER;
    cfg_data_i <= limit_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    iter_limit = 32'(limit_data[jet_pkg::MAXIT_W-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_pixels(input int count);
    jet_pkg::req_t px;
    for (int k = 0; k < count; k++) begin
      px = random_pixel();
      send_pixel(px.pixel_x, px.pixel_y);
    end
    settle();
  endtask

  task automatic test_reset_state();
    send_pixel(0, 0);
    send_pixel(1919, 0);
    send_pixel(0, 1079);
    send_pixel(1919, 1079);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(832, 432);
    settle();
  endtask

  task automatic test_zero_limit();
    load_julia_params(32'd0, 32'd0, 32'd0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(832, 432);
    settle();
  endtask

  task automatic test_last_iteration_escape();
    load_julia_params(32'd0, 32'd0, 32'd1);
    send_pixel(0, 0);
    send_pixel(832, 432);
    settle();
    load_julia_params(32'd0, 32'd0, 32'd2);
    send_pixel(0, 0);
    settle();
  endtask

  task automatic test_longest_limit();
    load_julia_params(32'd0, 32'd0, 32'd65535);
    send_pixel(4095, 4095);
    send_pixel(832, 432);
    settle();
  endtask

  task automatic test_wide_register_data();
    load_julia_params(32'h8000_0000 | C_PLUS_TWO, 32'h8000_0000 | C_MINUS_TWO, 32'hABCD_0010);
    send_pixel(832, 432);
    send_pixel(0, 0);
    send_pixel(1000, 600);
    send_pixel(4095, 4095);
    settle();
  endtask

  task automatic test_classic_constant();
    load_julia_params(32'(-214748365), 32'd41875931, 32'd64);
    run_random_pixels(300);
  endtask

  task automatic test_default_limit();
    load_julia_params(32'd0, 32'd0, 32'd256);
    run_random_pixels(150);
  endtask

  task automatic test_random_constants();
    for (int round = 0; round < 4; round++) begin
      load_julia_params(random_constant(), random_constant(),
                        {16'($urandom), 16'($urandom_range(1, 40))});
      run_random_pixels(100);
    end
  endtask

  task automatic test_extreme_constants();
    load_julia_params(C_PLUS_TWO, C_MINUS_TWO, 32'd32);
    run_random_pixels(100);
    load_julia_params(C_MINUS_TWO, C_PLUS_TWO, 32'd32);
    run_random_pixels(100);
  endtask

  task automatic test_tiny_limits();
    load_julia_params(random_constant(), random_constant(), 32'd1);
    run_random_pixels(50);
    load_julia_params(random_constant(), random_constant(), 32'd0);
    run_random_pixels(50);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    load_julia_params(32'(-107374182), 32'd161061274, 32'd48);
    run_random_pixels(150);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_checked++;
      if (res_o.inside_res) begin
        inside_seen++;
      end
      if (int'(res_o.iterations) > deepest_count) begin
        deepest_count = int'(res_o.iterations);
      end
      if (expected_res_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, actual %p", $time, res_o);
      end else begin
        next_res = expected_res_q.pop_front();
        if (res_o.iterations !== next_res.iterations) begin
          mismatch_count++;
          $display("%0t: iterations expected %0d actual %0d", $time,
                   next_res.iterations, res_o.iterations);
        end
        if (res_o.inside_res !== next_res.inside_res) begin
          mismatch_count++;
          $display("%0t: inside_res expected %0d actual %0d", $time,
                   next_res.inside_res, res_o.inside_res);
        end
        if (res_o.out_x !== next_res.out_x) begin
          mismatch_count++;
          $display("%0t: out_x expected %0d actual %0d", $time, next_res.out_x, res_o.out_x);
        end
        if (res_o.out_y !== next_res.out_y) begin
          mismatch_count++;
          $display("%0t: out_y expected %0d actual %0d", $time, next_res.out_y, res_o.out_y);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request, result or register write for %0d cycles", $time, idle_cycles);
      $display("julia_escape_time_iterator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= jet_pkg::CFG_C_REAL;
    cfg_data_i <= '0;
    c_re = 0;
    c_im = 0;
    iter_limit = 256;
    idle_on = 1'b1;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_zero_limit();
    test_last_iteration_escape();
    test_longest_limit();
    test_wide_register_data();
    test_classic_constant();
    test_default_limit();
    test_random_constants();
    test_extreme_constants();
    test_tiny_limits();
    test_steady_stream();

    $display("Sent %0d pixels and checked %0d results, %0d of them inside the set.",
             items_sent, results_checked, inside_seen);
    $display("Deepest count was %0d iterations; constants reached both ends of their range.",
             deepest_count);
    if (mismatch_count == 0 && expected_res_q.size() == 0) begin
      $display("julia_escape_time_iterator_tb: PASS");
    end else begin
      $display("julia_escape_time_iterator_tb: FAIL");
    end
    $finish;
  end

endmodule
